>>> hdl/slr_pkg.sv
// Shared constants, types and register codes for the sliding-log rate limiter.
package slr_pkg;

   localparam int unsigned NUM_CLIENTS_DEF      = 256;
   localparam int unsigned MAX_LIMIT_DEF        = 64;
   localparam int unsigned TICKS_PER_SECOND_DEF = 1000;

   localparam int unsigned SLOT_W     = 8;
   localparam int unsigned NOW_W      = 32;
   localparam int unsigned LIMIT_W    = 7;
   localparam int unsigned WINDOW_W   = 22;
   localparam int unsigned RETRY_W    = 12;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 22;

   localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 7'd60;
   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 22'd60000;
   localparam logic [RETRY_W-1:0]  RETRY_MAX    = 12'd4095;
   localparam logic [RETRY_W-1:0]  RETRY_MIN    = 12'd1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REQUEST_LIMIT = 2'd0,
      CSR_WINDOW_MS     = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic [NOW_W-1:0]  now;
   } req_type;

   typedef struct packed {
      logic pop;
      logic clearing;
   } back_ctl_type;

endpackage

>>> hdl/sliding_log_rate_limiter_core.sv
// Top level of the sliding-log rate limiter: register port, intake queue and ring engine.
// A request (client slot, millisecond time) is taken when start is high and busy is low;
// its single response appears on the rsp_ ports for one cycle with rsp_valid high and
// cannot be held off. In the ring engine each request passes the reduce, meta-read, meta,
// check and decide states, with one read of the stamp memory for every expired entry
// popped and one more when an unexpired entry is left in the ring; a denied request with
// a non-empty ring adds a state for the retry scaling by reciprocal multiplication. Slots
// at or above NUM_CLIENTS add one reduction step per subtraction of NUM_CLIENTS. Two
// requests can wait in the intake queue. After reset the per-client head/count table is
// cleared, one slot per cycle, with busy high throughout; register writes are taken
// meanwhile.
module sliding_log_rate_limiter_core import slr_pkg::*; #(
   parameter int unsigned NUM_CLIENTS      = NUM_CLIENTS_DEF,
   parameter int unsigned MAX_LIMIT        = MAX_LIMIT_DEF,
   parameter int unsigned TICKS_PER_SECOND = TICKS_PER_SECOND_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [SLOT_W-1:0]     req_client_slot,
   input  logic [NOW_W-1:0]      req_now_ms,
   output logic                  rsp_valid,
   output logic                  rsp_allowed,
   output logic [RETRY_W-1:0]    rsp_retry_after_s,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [LIMIT_W-1:0]  limit_ff;
   logic [WINDOW_W-1:0] window_ff;
   req_type             req;
   req_type             q_head;
   logic                q_valid;
   back_ctl_type        ctl;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff  <= LIMIT_RESET;
         window_ff <= WINDOW_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_REQUEST_LIMIT: limit_ff  <= csr_wdata[LIMIT_W-1:0];
            CSR_WINDOW_MS:     window_ff <= csr_wdata[WINDOW_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign req.slot = req_client_slot;
   assign req.now  = req_now_ms;

   slr_front u_front (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req     (req),
      .ctl     (ctl),
      .busy    (busy),
      .q_valid (q_valid),
      .q_head  (q_head)
   );

   slr_back #(
      .NUM_CLIENTS      (NUM_CLIENTS),
      .MAX_LIMIT        (MAX_LIMIT),
      .TICKS_PER_SECOND (TICKS_PER_SECOND)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_head            (q_head),
      .request_limit     (limit_ff),
      .window_ms         (window_ff),
      .ctl               (ctl),
      .rsp_valid         (rsp_valid),
      .rsp_allowed       (rsp_allowed),
      .rsp_retry_after_s (rsp_retry_after_s)
   );

endmodule

>>> hdl/slr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module slr_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                            wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                            rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

>>> hdl/slr_front.sv
// Request intake: two-entry queue between the command port and the ring engine.
module slr_front import slr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  req_type      req,
   input  back_ctl_type ctl,
   output logic         busy,
   output logic         q_valid,
   output req_type      q_head
);

   logic [1:0] cnt_ff, cnt_in;
   logic       wp_ff, wp_in;
   logic       rp_ff, rp_in;
   req_type    mem_ff [2];
   logic       push;
   logic       pop;

   assign busy    = (cnt_ff == 2'd2) || ctl.clearing;
   assign push    = start && !busy;
   assign pop     = ctl.pop && (cnt_ff != 2'd0);
   assign q_valid = (cnt_ff != 2'd0);
   assign q_head  = mem_ff[rp_ff];

   always_comb begin
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
      end
      if (push) begin
         mem_ff[wp_ff] <= req;
      end
   end

endmodule

>>> hdl/slr_back.sv
// Ring engine: per-client expiry, limit decision, retry division and ring update.
module slr_back import slr_pkg::*; #(
   parameter int unsigned NUM_CLIENTS      = NUM_CLIENTS_DEF,
   parameter int unsigned MAX_LIMIT        = MAX_LIMIT_DEF,
   parameter int unsigned TICKS_PER_SECOND = TICKS_PER_SECOND_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  req_type             q_head,
   input  logic [LIMIT_W-1:0]  request_limit,
   input  logic [WINDOW_W-1:0] window_ms,
   output back_ctl_type        ctl,
   output logic                rsp_valid,
   output logic                rsp_allowed,
   output logic [RETRY_W-1:0]  rsp_retry_after_s
);

   localparam int unsigned CL_W    = NUM_CLIENTS > 1 ? $clog2(NUM_CLIENTS) : 1;
   localparam int unsigned HD_W    = MAX_LIMIT > 1 ? $clog2(MAX_LIMIT) : 1;
   localparam int unsigned CNT_W   = $clog2(MAX_LIMIT + 1);
   localparam int unsigned SA_D    = NUM_CLIENTS * MAX_LIMIT;
   localparam int unsigned SA_W    = SA_D > 1 ? $clog2(SA_D) : 1;
   localparam int unsigned LIM_W   = CNT_W > LIMIT_W ? CNT_W : LIMIT_W;
   localparam int unsigned META_W  = HD_W + CNT_W;
   localparam int unsigned DIV_W   = WINDOW_W;
   // floor(x / T) == (x * M) >> K for every x below 2^DIV_W
   localparam int unsigned RECIP_K = DIV_W + $clog2(TICKS_PER_SECOND);
   localparam int unsigned RECIP_W = DIV_W + 1;
   localparam int unsigned PROD_W  = DIV_W + RECIP_W;
   localparam longint unsigned RECIP_M =
      ((64'd1 << RECIP_K) + 64'(TICKS_PER_SECOND) - 64'd1) / 64'(TICKS_PER_SECOND);

   typedef enum logic [8:0] {
      S_CLEAR   = 9'b000000001,
      S_IDLE    = 9'b000000010,
      S_REDUCE  = 9'b000000100,
      S_META_RD = 9'b000001000,
      S_META    = 9'b000010000,
      S_CHECK   = 9'b000100000,
      S_STAMP   = 9'b001000000,
      S_DECIDE  = 9'b010000000,
      S_DIV     = 9'b100000000
   } state_type;

   state_type           state_ff, state_in;
   logic [CL_W-1:0]     clr_ff, clr_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [NOW_W-1:0]    now_ff, now_in;
   logic [HD_W-1:0]     head_ff, head_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [WINDOW_W-1:0] age_ff, age_in;
   logic [DIV_W-1:0]    quot_ff, quot_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_allowed_ff, rsp_allowed_in;
   logic [RETRY_W-1:0]  rsp_retry_ff, rsp_retry_in;

   logic [CL_W-1:0]     cl_idx;
   logic [SA_W-1:0]     base;
   logic                meta_we;
   logic [CL_W-1:0]     meta_waddr;
   logic [META_W-1:0]   meta_wdata;
   logic [META_W-1:0]   meta_rdata;
   logic                stamp_we;
   logic [SA_W-1:0]     stamp_waddr;
   logic [NOW_W-1:0]    stamp_rdata;
   logic [NOW_W-1:0]    age;
   logic [LIM_W-1:0]    limit_eff;
   logic [CNT_W:0]      pos_sum;
   logic [HD_W-1:0]     pos;
   logic [HD_W-1:0]     head_next;
   logic [PROD_W-1:0]   prod;
   logic [DIV_W-1:0]    quot_done;

   assign cl_idx = CL_W'(slot_ff);
   assign base   = SA_W'(cl_idx) * SA_W'(MAX_LIMIT);
   assign age    = now_ff - stamp_rdata;

   assign limit_eff = (LIM_W'(request_limit) > LIM_W'(MAX_LIMIT)) ?
                      LIM_W'(MAX_LIMIT) : LIM_W'(request_limit);
   assign pos_sum   = (CNT_W + 1)'(head_ff) + (CNT_W + 1)'(count_ff);
   assign pos       = (pos_sum >= (CNT_W + 1)'(MAX_LIMIT)) ?
                      HD_W'(pos_sum - (CNT_W + 1)'(MAX_LIMIT)) : HD_W'(pos_sum);
   assign head_next = (head_ff == HD_W'(MAX_LIMIT - 1)) ? '0 : head_ff + HD_W'(1);

   assign prod      = PROD_W'(quot_ff) * PROD_W'(RECIP_M);
   assign quot_done = DIV_W'(prod >> RECIP_K);

   slr_ram #(.WIDTH(META_W), .DEPTH(NUM_CLIENTS)) u_meta (
      .clock (clock),
      .we    (meta_we),
      .waddr (meta_waddr),
      .wdata (meta_wdata),
      .raddr (cl_idx),
      .rdata (meta_rdata)
   );

   slr_ram #(.WIDTH(NOW_W), .DEPTH(SA_D)) u_stamp (
      .clock (clock),
      .we    (stamp_we),
      .waddr (stamp_waddr),
      .wdata (now_ff),
      .raddr (base + SA_W'(head_ff)),
      .rdata (stamp_rdata)
   );

   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      slot_in        = slot_ff;
      now_in         = now_ff;
      head_in        = head_ff;
      count_in       = count_ff;
      age_in         = age_ff;
      quot_in        = quot_ff;
      rsp_valid_in   = 1'b0;
      rsp_allowed_in = rsp_allowed_ff;
      rsp_retry_in   = rsp_retry_ff;
      meta_we        = 1'b0;
      meta_waddr     = cl_idx;
      meta_wdata     = {head_ff, count_ff};
      stamp_we       = 1'b0;
      stamp_waddr    = base + SA_W'(pos);
      ctl.pop        = 1'b0;
      ctl.clearing   = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            ctl.clearing = 1'b1;
            meta_we      = 1'b1;
            meta_waddr   = clr_ff;
            meta_wdata   = '0;
            clr_in       = clr_ff + CL_W'(1);
            if (clr_ff == CL_W'(NUM_CLIENTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (q_valid) begin
               ctl.pop  = 1'b1;
               slot_in  = q_head.slot;
               now_in   = q_head.now;
               state_in = S_REDUCE;
            end
         end
         S_REDUCE: begin
            if (32'(slot_ff) >= 32'(NUM_CLIENTS)) begin
               slot_in = slot_ff - SLOT_W'(NUM_CLIENTS);
            end else begin
               state_in = S_META_RD;
            end
         end
         S_META_RD: begin
            state_in = S_META;
         end
         S_META: begin
            head_in  = meta_rdata[META_W-1:CNT_W];
            count_in = meta_rdata[CNT_W-1:0];
            state_in = S_CHECK;
         end
         S_CHECK: begin
            state_in = (count_ff != '0) ? S_STAMP : S_DECIDE;
         end
         S_STAMP: begin
            if (age > NOW_W'(window_ms)) begin
               head_in  = head_next;
               count_in = count_ff - CNT_W'(1);
               state_in = S_CHECK;
            end else begin
               age_in   = age[WINDOW_W-1:0];
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            meta_we = 1'b1;
            if (LIM_W'(count_ff) >= limit_eff) begin
               if (count_ff == '0) begin
                  rsp_valid_in   = 1'b1;
                  rsp_allowed_in = 1'b0;
                  rsp_retry_in   = RETRY_MIN;
                  state_in       = S_IDLE;
               end else begin
                  quot_in  = window_ms - age_ff;
                  state_in = S_DIV;
               end
            end else begin
               stamp_we       = 1'b1;
               meta_wdata     = {head_ff, count_ff + CNT_W'(1)};
               rsp_valid_in   = 1'b1;
               rsp_allowed_in = 1'b1;
               rsp_retry_in   = '0;
               state_in       = S_IDLE;
            end
         end
         S_DIV: begin
            rsp_valid_in   = 1'b1;
            rsp_allowed_in = 1'b0;
            if (quot_done == '0) begin
               rsp_retry_in = RETRY_MIN;
            end else if (quot_done > DIV_W'(RETRY_MAX)) begin
               rsp_retry_in = RETRY_MAX;
            end else begin
               rsp_retry_in = RETRY_W'(quot_done);
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      slot_ff        <= slot_in;
      now_ff         <= now_in;
      head_ff        <= head_in;
      count_ff       <= count_in;
      age_ff         <= age_in;
      quot_ff        <= quot_in;
      rsp_allowed_ff <= rsp_allowed_in;
      rsp_retry_ff   <= rsp_retry_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_allowed       = rsp_allowed_ff;
   assign rsp_retry_after_s = rsp_retry_ff;

   a_allow_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_allowed_ff |-> rsp_retry_ff == '0)
      else $error("allowed request with nonzero retry");

   a_deny_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_allowed_ff |-> rsp_retry_ff != '0)
      else $error("denied request with zero retry");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DECIDE |-> 32'(count_ff) <= 32'(MAX_LIMIT))
      else $error("ring count above capacity");

   a_pop_moves: assert property (@(posedge clock) disable iff (reset)
      ctl.pop |=> state_ff == S_REDUCE)
      else $error("queue pop without starting a request");

endmodule

>>> tb/sliding_log_rate_limiter_core_test.sv
// Self-checking testbench for the sliding-log rate limiter core.
`timescale 1ns / 100ps

module sliding_log_rate_limiter_core_test;
   import slr_pkg::*;

   typedef struct {
      logic [SLOT_W-1:0] slot;
      logic [NOW_W-1:0]  now;
      int                gap;
   } pending_type;

   typedef struct {
      logic               allowed;
      logic [RETRY_W-1:0] retry;
   } verdict_type;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [SLOT_W-1:0]     req_client_slot;
   logic [NOW_W-1:0]      req_now_ms;
   logic                  rsp_valid;
   logic                  rsp_allowed;
   logic [RETRY_W-1:0]    rsp_retry_after_s;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   pending_type pending_q[$];
   verdict_type verdict_q[$];
   int          mismatch_count;
   int          gap_left;
   logic        driving;
   logic        taken;

   logic [31:0] log_stamp[NUM_CLIENTS_DEF][MAX_LIMIT_DEF];
   int unsigned log_head[NUM_CLIENTS_DEF];
   int unsigned log_count[NUM_CLIENTS_DEF];
   int unsigned limit_cfg;
   logic [31:0] window_cfg;

   sliding_log_rate_limiter_core i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_client_slot(req_client_slot), .req_now_ms(req_now_ms),
      .rsp_valid(rsp_valid), .rsp_allowed(rsp_allowed),
      .rsp_retry_after_s(rsp_retry_after_s),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic verdict_type judge_request(logic [SLOT_W-1:0] slot, logic [31:0] now);
      int unsigned s;
      int unsigned lim;
      int unsigned hd;
      int unsigned cnt;
      logic [31:0] age;
      logic [31:0] left;
      logic [31:0] r;
      verdict_type v;
      s = slot;
      lim = (limit_cfg > MAX_LIMIT_DEF) ? MAX_LIMIT_DEF : limit_cfg;
      hd = log_head[s];
      cnt = log_count[s];
      while (cnt > 0) begin
         age = now - log_stamp[s][hd];
         if (age <= window_cfg) break;
         hd = (hd + 1) % MAX_LIMIT_DEF;
         cnt--;
      end
      if (cnt >= lim) begin
         r = 1;
         if (cnt > 0) begin
            age = now - log_stamp[s][hd];
            left = window_cfg - age;
            r = left / TICKS_PER_SECOND_DEF;
            if (r < 1) r = 1;
            if (r > RETRY_MAX) r = RETRY_MAX;
         end
         v.allowed = 1'b0;
         v.retry = r[RETRY_W-1:0];
      end else begin
         log_stamp[s][(hd + cnt) % MAX_LIMIT_DEF] = now;
         cnt++;
         v.allowed = 1'b1;
         v.retry = '0;
      end
      log_head[s] = hd;
      log_count[s] = cnt;
      return v;
   endfunction

   // request taken at this rising edge
   always @(posedge clock) begin
      taken <= !reset && start && !busy;
   end

   // driver
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left <= 0;
      end else if (taken) begin
         verdict_q.insert(verdict_q.size(), judge_request(req_client_slot, req_now_ms));
         start <= 1'b0;
         gap_left <= 0;
      end else if (!start && driving && pending_q.size() > 0) begin
         if (gap_left < pending_q[0].gap) begin
            gap_left <= gap_left + 1;
         end else begin
            pending_type p;
            p = pending_q.pop_front();
            req_client_slot <= p.slot;
            req_now_ms <= p.now;
            start <= 1'b1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (verdict_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response allowed=%0d retry=%0d",
                        rsp_allowed, rsp_retry_after_s);
         end else begin
            verdict_type e;
            e = verdict_q.pop_front();
            if (e.allowed !== rsp_allowed || e.retry !== rsp_retry_after_s) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected allowed=%0d retry=%0d, got allowed=%0d retry=%0d",
                           e.allowed, e.retry, rsp_allowed, rsp_retry_after_s);
            end
         end
      end
   end

   task automatic queue_request(int slot, logic [31:0] now, int gap);
      pending_type p;
      p.slot = SLOT_W'(slot);
      p.now = now;
      p.gap = gap;
      pending_q.insert(pending_q.size(), p);
   endtask

   task automatic drain();
      while (pending_q.size() > 0 || start || verdict_q.size() > 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, int unsigned val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(val);
      if (idx == CSR_REQUEST_LIMIT) limit_cfg = val & 32'h7f;
      else window_cfg = val & 32'h3fffff;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic random_phase(int n, int slots, int unsigned step_max);
      logic [31:0] clk_ms;
      int slot;
      clk_ms = $urandom;
      for (int i = 0; i < n; i++) begin
         clk_ms += $urandom_range(0, step_max);
         slot = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                             : $urandom_range(0, slots - 1);
         if ($urandom_range(0, 15) == 0) queue_request(slot, $urandom, $urandom_range(0, 16));
         else queue_request(slot, clk_ms,
                            ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16));
      end
   endtask

   initial begin
      mismatch_count = 0;
      driving = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_client_slot = '0;
      req_now_ms = '0;
      csr_we = 1'b0;
      csr_index = CSR_REQUEST_LIMIT;
      csr_wdata = '0;
      limit_cfg = LIMIT_RESET;
      window_cfg = WINDOW_RESET;
      foreach (log_head[i]) begin
         log_head[i] = 0;
         log_count[i] = 0;
      end
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: limit 0, empty ring
      write_csr(CSR_REQUEST_LIMIT, 0);
      write_csr(CSR_WINDOW_MS, 5000);
      driving = 1'b1;
      queue_request(0, 0, 0);
      queue_request(255, 32'hffffffff, 0);
      drain();
      write_csr(CSR_REQUEST_LIMIT, 2);
      queue_request(255, 32'hffffff00, 0);
      queue_request(255, 32'hffffff10, 0);
      queue_request(255, 32'hffffff20, 3);
      queue_request(255, 32'h00000500, 0);
      queue_request(255, 32'h00002000, 0);
      queue_request(1, 100, 0);
      queue_request(1, 200, 0);
      queue_request(1, 5200, 0);
      queue_request(1, 5201, 0);
      drain();
      // large window for saturation, then window zero and limit above capacity
      write_csr(CSR_WINDOW_MS, 22'h3fffff);
      write_csr(CSR_REQUEST_LIMIT, 1);
      queue_request(2, 10, 0);
      queue_request(2, 11, 0);
      queue_request(2, 12, 0);
      drain();
      write_csr(CSR_WINDOW_MS, 0);
      write_csr(CSR_REQUEST_LIMIT, 127);
      queue_request(3, 7, 0);
      queue_request(3, 7, 0);
      queue_request(3, 8, 0);
      drain();

      write_csr(CSR_REQUEST_LIMIT, 64);
      write_csr(CSR_WINDOW_MS, 3600000);
      for (int i = 0; i < 70; i++) queue_request(4, i * 10, $urandom_range(0, 2));
      drain();

      write_csr(CSR_REQUEST_LIMIT, 3);
      write_csr(CSR_WINDOW_MS, 2000);
      random_phase(450, 6, 900);
      drain();
      write_csr(CSR_REQUEST_LIMIT, 8);
      write_csr(CSR_WINDOW_MS, 60000);
      random_phase(450, 4, 9000);
      drain();
      write_csr(CSR_REQUEST_LIMIT, $urandom_range(0, 64));
      write_csr(CSR_WINDOW_MS, $urandom_range(1, 3600000));
      random_phase(400, 8, 200000);
      drain();
      write_csr(CSR_REQUEST_LIMIT, 64);
      write_csr(CSR_WINDOW_MS, 1);
      random_phase(300, 3, 2);
      drain();

      if (mismatch_count == 0 && verdict_q.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #20ms;
      $display("TB_ERROR");
      $finish;
   end

endmodule

>>> sliding_log_rate_limiter_core.f
hdl/slr_pkg.sv
hdl/slr_ram.sv
hdl/slr_front.sv
hdl/slr_back.sv
hdl/sliding_log_rate_limiter_core.sv
tb/sliding_log_rate_limiter_core_test.sv
